/* design/sdc_pkg.sv */
// shared widths, register indexes and limits of the dipolar coupling pipeline
package sdc_pkg;

  localparam int COORD_W  = 32;
  localparam int DIFF_W   = 33;
  localparam int SQ_W     = 2 * DIFF_W;
  localparam int SUM_W    = SQ_W + 2;
  localparam int ROOT_W   = SUM_W / 2;
  localparam int GYRO_W   = 32;
  localparam int HBAR_W   = 32;
  localparam int DIST_W   = 31;
  localparam int IDX_W    = 11;
  localparam int NUM_W    = HBAR_W + 3 * GYRO_W;
  localparam int CUBE_W   = 3 * ROOT_W;
  localparam int DEN_SH   = 16;
  localparam int DEN_W    = CUBE_W + DEN_SH;
  localparam int QUO_W    = 32;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_OUTER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INNER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HBAR  = 2'd2;

  localparam logic [DIST_W-1:0] OUTER_RESET = 31'd327680;
  localparam logic [DIST_W-1:0] INNER_RESET = 31'd0;
  localparam logic [HBAR_W-1:0] HBAR_RESET  = 32'd65536;

  localparam logic [QUO_W-1:0] STRENGTH_MAX = {QUO_W{1'b1}};

endpackage

/* design/sdc_delay.sv */
// payload shift line with a common advance enable
module sdc_delay #(
  parameter int W     = 8,
  parameter int DEPTH = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] line [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      line[0] <= d;
      for (int i = 1; i < DEPTH; i++) begin
        line[i] <= line[i-1];
      end
    end
  end

  assign q = line[DEPTH-1];

endmodule

/* design/sdc_mul.sv */
// pipelined multiplier, one 32-bit limb of a per stage
module sdc_mul #(
  parameter int WA = 32,
  parameter int WB = 32
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WA-1:0]    a,
  input  logic [WB-1:0]    b,
  output logic [WA+WB-1:0] p
);

  localparam int L  = (WA + 31) / 32;
  localparam int WP = L * 32;
  localparam int WO = WA + WB;

  logic [WO-1:0] acc   [L];
  logic [WP-1:0] a_reg [L];
  logic [WB-1:0] b_reg [L];
  logic [WP-1:0] a_pad;

  assign a_pad = WP'(a);

  always_ff @(posedge clk) begin
    if (en) begin
      acc[0]   <= WO'(a_pad[31:0] * b);
      a_reg[0] <= a_pad;
      b_reg[0] <= b;
      for (int k = 1; k < L; k++) begin
        acc[k]   <= acc[k-1] + (WO'(a_reg[k-1][32*k +: 32] * b_reg[k-1]) << (32 * k));
        a_reg[k] <= a_reg[k-1];
        b_reg[k] <= b_reg[k-1];
      end
    end
  end

  assign p = acc[L-1];

endmodule

/* design/sdc_sqrt.sv */
// pipelined integer square root, one root bit per stage
module sdc_sqrt
  import sdc_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [SUM_W-1:0]  s,
  output logic [ROOT_W-1:0] r
);

  localparam int RW = SUM_W + 2;

  logic [RW-1:0]     rem  [ROOT_W];
  logic [ROOT_W-1:0] root [ROOT_W];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < ROOT_W; j++) begin
        logic [RW-1:0]     rp;
        logic [ROOT_W-1:0] qp;
        logic [RW-1:0]     t;
        rp = (j == 0) ? RW'(s) : rem[j == 0 ? 0 : j-1];
        qp = (j == 0) ? '0 : root[j == 0 ? 0 : j-1];
        t  = (RW'(qp) << (ROOT_W - j)) | (RW'(1) << (2 * (ROOT_W - 1 - j)));
        if (rp >= t) begin
          rem[j]  <= rp - t;
          root[j] <= qp | (ROOT_W'(1) << (ROOT_W - 1 - j));
        end else begin
          rem[j]  <= rp;
          root[j] <= qp;
        end
      end
    end
  end

  assign r = root[ROOT_W-1];

endmodule

/* design/sdc_div.sv */
// overflow check and pipelined restoring divider, one quotient bit per stage
module sdc_div
  import sdc_pkg::*;
(
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [QUO_W-1:0] quo,
  output logic             sat
);

  localparam int RW = DEN_W + QUO_W;

  logic [RW-1:0]    rem   [QUO_W+1];
  logic [DEN_W-1:0] dreg  [QUO_W+1];
  logic [QUO_W-1:0] q     [QUO_W+1];
  logic             ovf   [QUO_W+1];

  always_ff @(posedge clk) begin
    if (en) begin
      // zero divisor also lands here
      rem[0]  <= RW'(num);
      dreg[0] <= den;
      q[0]    <= '0;
      ovf[0]  <= RW'(num) >= (RW'(den) << QUO_W);
      for (int j = 1; j <= QUO_W; j++) begin
        logic [RW-1:0] t;
        t = RW'(dreg[j-1]) << (QUO_W - j);
        dreg[j] <= dreg[j-1];
        ovf[j]  <= ovf[j-1];
        if (rem[j-1] >= t) begin
          rem[j] <= rem[j-1] - t;
          q[j]   <= q[j-1] | (QUO_W'(1) << (QUO_W - j));
        end else begin
          rem[j] <= rem[j-1];
          q[j]   <= q[j-1];
        end
      end
    end
  end

  assign quo = ovf[QUO_W] ? STRENGTH_MAX : q[QUO_W];
  assign sat = ovf[QUO_W];

endmodule

/* design/spin_pair_dipolar_coupling.sv */
// top level: dipolar coupling strength and connection flag of one spin pair
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------
//  in      | in_valid / in_stall  | positions, gyro ratios, coupling_zz, row/col
//  out     | out_valid / out_stall| row_out, col_out, connected, strength, saturated
//  config  | cfg_write            | cfg_index, cfg_data
//
//  one item per cycle unless a stalled result holds the pipeline
//  latency mostly set by the 34-stage square root and the 33-stage divider
//  whole pipeline advances together; a stalled result holds every stage
//  reset clears valid bits and loads the register defaults
module spin_pair_dipolar_coupling
  import sdc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [COORD_W-1:0]   first_x,
  input  logic [COORD_W-1:0]   first_y,
  input  logic [COORD_W-1:0]   first_z,
  input  logic [COORD_W-1:0]   second_x,
  input  logic [COORD_W-1:0]   second_y,
  input  logic [COORD_W-1:0]   second_z,
  input  logic [GYRO_W-1:0]    first_gyro,
  input  logic [GYRO_W-1:0]    second_gyro,
  input  logic [COORD_W-1:0]   coupling_zz,
  input  logic [IDX_W-1:0]     pair_row,
  input  logic [IDX_W-1:0]     pair_col,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [IDX_W-1:0]     row_out,
  output logic [IDX_W-1:0]     col_out,
  output logic                 connected,
  output logic [QUO_W-1:0]     strength,
  output logic                 saturated,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  localparam int SQ_LAT  = (DIFF_W + 31) / 32;
  localparam int R2_LAT  = (ROOT_W + 31) / 32;
  localparam int R3_LAT  = (2 * ROOT_W + 31) / 32;
  localparam int N1_LAT  = (HBAR_W + 31) / 32;
  localparam int N2_LAT  = (HBAR_W + GYRO_W + 31) / 32;
  localparam int N3_LAT  = (HBAR_W + 2 * GYRO_W + 31) / 32;
  localparam int POS_SUM = 1 + SQ_LAT + 1;
  localparam int POS_R   = POS_SUM + ROOT_W;
  localparam int POS_R3  = POS_R + R2_LAT + R3_LAT;
  localparam int POS_N   = 1 + N1_LAT + N2_LAT + N3_LAT;
  localparam int TOTAL   = POS_R3 + QUO_W + 1;

  logic [DIST_W-1:0] outer_distance;
  logic [DIST_W-1:0] inner_distance;
  logic [HBAR_W-1:0] hbar_scale;

  always_ff @(posedge clk) begin
    if (rst) begin
      outer_distance <= OUTER_RESET;
      inner_distance <= INNER_RESET;
      hbar_scale     <= HBAR_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_OUTER: outer_distance <= cfg_data[DIST_W-1:0];
        REG_INNER: inner_distance <= cfg_data[DIST_W-1:0];
        REG_HBAR:  hbar_scale     <= cfg_data[HBAR_W-1:0];
        default: ;
      endcase
    end
  end

  logic         en;
  logic [TOTAL-1:0] vpipe;

  assign en        = !(vpipe[TOTAL-1] && out_stall);
  assign in_stall  = !en;
  assign out_valid = vpipe[TOTAL-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else if (en) begin
      vpipe <= {vpipe[TOTAL-2:0], in_valid};
    end
  end

  function automatic logic [DIFF_W-1:0] diff_mag(input logic [COORD_W-1:0] a,
                                                 input logic [COORD_W-1:0] b);
    logic [DIFF_W-1:0] d;
    d = {b[COORD_W-1], b} - {a[COORD_W-1], a};
    return d[DIFF_W-1] ? -d : d;
  endfunction

  function automatic logic [GYRO_W-1:0] mag32(input logic [GYRO_W-1:0] v);
    return v[GYRO_W-1] ? -v : v;
  endfunction

  // first stage: differences and magnitudes
  logic [DIFF_W-1:0] dx, dy, dz;
  logic [GYRO_W-1:0] mg1, mg2, mzz;
  logic [IDX_W-1:0]  row1, col1;

  always_ff @(posedge clk) begin
    if (en) begin
      dx   <= diff_mag(first_x, second_x);
      dy   <= diff_mag(first_y, second_y);
      dz   <= diff_mag(first_z, second_z);
      mg1  <= mag32(first_gyro);
      mg2  <= mag32(second_gyro);
      mzz  <= mag32(coupling_zz);
      row1 <= pair_row;
      col1 <= pair_col;
    end
  end

  // distance
  logic [SQ_W-1:0]   sqx, sqy, sqz;
  logic [SUM_W-1:0]  sum_sq;
  logic [ROOT_W-1:0] r;

  sdc_mul #(.WA(DIFF_W), .WB(DIFF_W)) u_sqx (.clk, .en, .a(dx), .b(dx), .p(sqx));
  sdc_mul #(.WA(DIFF_W), .WB(DIFF_W)) u_sqy (.clk, .en, .a(dy), .b(dy), .p(sqy));
  sdc_mul #(.WA(DIFF_W), .WB(DIFF_W)) u_sqz (.clk, .en, .a(dz), .b(dz), .p(sqz));

  always_ff @(posedge clk) begin
    if (en) begin
      sum_sq <= SUM_W'(sqx) + SUM_W'(sqy) + SUM_W'(sqz);
    end
  end

  sdc_sqrt u_sqrt (.clk, .en, .s(sum_sq), .r(r));

  logic conn_r;
  assign conn_r = (r > ROOT_W'(inner_distance)) && (r < ROOT_W'(outer_distance));

  // cube of distance
  logic [2*ROOT_W-1:0] r2;
  logic [ROOT_W-1:0]   r_d;
  logic [CUBE_W-1:0]   r3;

  sdc_mul #(.WA(ROOT_W), .WB(ROOT_W)) u_r2 (.clk, .en, .a(r), .b(r), .p(r2));
  sdc_delay #(.W(ROOT_W), .DEPTH(R2_LAT)) u_rd (.clk, .en, .d(r), .q(r_d));
  sdc_mul #(.WA(2 * ROOT_W), .WB(ROOT_W)) u_r3 (.clk, .en, .a(r2), .b(r_d), .p(r3));

  // numerator
  logic [HBAR_W+GYRO_W-1:0]   n1;
  logic [HBAR_W+2*GYRO_W-1:0] n2;
  logic [NUM_W-1:0]           n3, n_al;
  logic [GYRO_W-1:0]          mg2_d, mzz_d;

  sdc_mul #(.WA(HBAR_W), .WB(GYRO_W)) u_n1 (.clk, .en, .a(hbar_scale), .b(mg1), .p(n1));
  sdc_delay #(.W(GYRO_W), .DEPTH(N1_LAT)) u_g2d (.clk, .en, .d(mg2), .q(mg2_d));
  sdc_mul #(.WA(HBAR_W + GYRO_W), .WB(GYRO_W)) u_n2 (.clk, .en, .a(n1), .b(mg2_d), .p(n2));
  sdc_delay #(.W(GYRO_W), .DEPTH(N1_LAT + N2_LAT)) u_zzd (.clk, .en, .d(mzz), .q(mzz_d));
  sdc_mul #(.WA(HBAR_W + 2 * GYRO_W), .WB(GYRO_W)) u_n3 (.clk, .en, .a(n2), .b(mzz_d),
                                                          .p(n3));
  sdc_delay #(.W(NUM_W), .DEPTH(POS_R3 - POS_N)) u_nd (.clk, .en, .d(n3), .q(n_al));

  // quotient
  sdc_div u_div (
    .clk, .en,
    .num(n_al),
    .den({r3, {DEN_SH{1'b0}}}),
    .quo(strength),
    .sat(saturated)
  );

  sdc_delay #(.W(1), .DEPTH(TOTAL - POS_R)) u_cd (.clk, .en, .d(conn_r), .q(connected));
  sdc_delay #(.W(2 * IDX_W), .DEPTH(TOTAL - 1)) u_idx (
    .clk, .en,
    .d({row1, col1}),
    .q({row_out, col_out})
  );

endmodule

/* dv/coupling_checker.sv */
// checker for the spin pair coupling block: predicts every result and compares it
`timescale 1ns / 1ps
module coupling_checker
  import sdc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [COORD_W-1:0]   first_x,
  input  logic [COORD_W-1:0]   first_y,
  input  logic [COORD_W-1:0]   first_z,
  input  logic [COORD_W-1:0]   second_x,
  input  logic [COORD_W-1:0]   second_y,
  input  logic [COORD_W-1:0]   second_z,
  input  logic [GYRO_W-1:0]    first_gyro,
  input  logic [GYRO_W-1:0]    second_gyro,
  input  logic [COORD_W-1:0]   coupling_zz,
  input  logic [IDX_W-1:0]     pair_row,
  input  logic [IDX_W-1:0]     pair_col,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [IDX_W-1:0]     row_out,
  input  logic [IDX_W-1:0]     col_out,
  input  logic                 connected,
  input  logic [QUO_W-1:0]     strength,
  input  logic                 saturated,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  output int                   fail_count,
  output int                   pending
);

  typedef struct packed {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             conn;
    logic [QUO_W-1:0] strength;
    logic             sat;
  } coupling_t;

  coupling_t          expected_couplings[$];
  logic [DIST_W-1:0]  outer_bound;
  logic [DIST_W-1:0]  inner_bound;
  logic [HBAR_W-1:0]  hbar;

  function automatic logic [32:0] axis_gap(input logic [31:0] a, input logic [31:0] b);
    logic signed [32:0] d;
    d = $signed({b[31], b}) - $signed({a[31], a});
    return d[32] ? 33'(-d) : 33'(d);
  endfunction

  function automatic logic [31:0] magnitude(input logic [31:0] v);
    return v[31] ? 32'(-v) : v;
  endfunction

  function automatic coupling_t predict_coupling();
    coupling_t     c;
    logic [69:0]   sum_sq, cand_sq;
    logic [32:0]   g;
    logic [33:0]   root, cand;
    logic [127:0]  num, den, quo;
    sum_sq = '0;
    g = axis_gap(first_x, second_x);
    sum_sq += 70'(g) * 70'(g);
    g = axis_gap(first_y, second_y);
    sum_sq += 70'(g) * 70'(g);
    g = axis_gap(first_z, second_z);
    sum_sq += 70'(g) * 70'(g);
    root = '0;
    for (int b = 33; b >= 0; b--) begin
      cand = root | (34'd1 << b);
      cand_sq = 70'(cand) * 70'(cand);
      if (cand_sq <= sum_sq) root = cand;
    end
    c.row = pair_row;
    c.col = pair_col;
    c.conn = (root > 34'(inner_bound)) && (root < 34'(outer_bound));
    if (root == 0) begin
      c.strength = STRENGTH_MAX;
      c.sat = 1'b1;
    end else begin
      num = 128'(hbar) * 128'(magnitude(first_gyro)) * 128'(magnitude(second_gyro))
            * 128'(magnitude(coupling_zz));
      den = (128'(root) * 128'(root) * 128'(root)) << 16;
      quo = num / den;
      if (quo[127:32] != 0) begin
        c.strength = STRENGTH_MAX;
        c.sat = 1'b1;
      end else begin
        c.strength = quo[31:0];
        c.sat = 1'b0;
      end
    end
    return c;
  endfunction

  always @(posedge clk) begin
    coupling_t exp_c;
    if (rst) begin
      outer_bound = OUTER_RESET;
      inner_bound = INNER_RESET;
      hbar = HBAR_RESET;
      expected_couplings.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_couplings.size() == 0) begin
          $display("%0t: unexpected result row %0d col %0d", $time, row_out, col_out);
          fail_count++;
        end else begin
          exp_c = expected_couplings.pop_front();
          if (row_out !== exp_c.row) begin
            $display("%0t: row_out expected %0d got %0d", $time, exp_c.row, row_out);
            fail_count++;
          end
          if (col_out !== exp_c.col) begin
            $display("%0t: col_out expected %0d got %0d", $time, exp_c.col, col_out);
            fail_count++;
          end
          if (connected !== exp_c.conn) begin
            $display("%0t: connected expected %0b got %0b", $time, exp_c.conn, connected);
            fail_count++;
          end
          if (strength !== exp_c.strength) begin
            $display("%0t: strength expected %h got %h", $time, exp_c.strength, strength);
            fail_count++;
          end
          if (saturated !== exp_c.sat) begin
            $display("%0t: saturated expected %0b got %0b", $time, exp_c.sat, saturated);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) expected_couplings.push_back(predict_coupling());
      if (cfg_write) begin
        case (cfg_index)
          REG_OUTER: outer_bound = cfg_data[DIST_W-1:0];
          REG_INNER: inner_bound = cfg_data[DIST_W-1:0];
          REG_HBAR:  hbar = cfg_data;
          default: ;
        endcase
      end
    end
    pending = expected_couplings.size();
  end

  initial begin
    fail_count = 0;
    pending = 0;
  end

endmodule

/* dv/tb_top.sv */
// testbench top: stimulus, idling, output stalling, register settings and verdict for the coupling block
`timescale 1ns / 1ps
module tb_top
  import sdc_pkg::*;
();

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int LIMIT_CYCLES = 2000000;
  localparam int PHASE_ITEMS = 450;

  typedef struct {
    logic [31:0] fx, fy, fz, sx, sy, sz, g1, g2, zz;
    logic [IDX_W-1:0] row, col;
  } pair_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0, in_stall, out_valid, out_stall = 1'b0;
  logic [31:0] first_x = '0, first_y = '0, first_z = '0;
  logic [31:0] second_x = '0, second_y = '0, second_z = '0;
  logic [31:0] first_gyro = '0, second_gyro = '0, coupling_zz = '0;
  logic [IDX_W-1:0] pair_row = '0, pair_col = '0, row_out, col_out;
  logic connected, saturated;
  logic [QUO_W-1:0] strength;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;
  int fail_count, pending;
  int send_idle_pct = 0, stall_pct = 0;
  int cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  spin_pair_dipolar_coupling i_dut (.*);
  coupling_checker i_checker (.*);

  always @(negedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic logic [31:0] rnd_val();
    logic [31:0] v;
    v = $urandom >> $urandom_range(31);
    return $urandom_range(1) ? 32'(-v) : v;
  endfunction

  function automatic logic [31:0] offset(input int span);
    return 32'($urandom_range(2 * span) - span);
  endfunction

  function automatic pair_t rand_pair();
    pair_t p;
    int mode;
    mode = $urandom_range(9);
    p.fx = rnd_val(); p.fy = rnd_val(); p.fz = rnd_val();
    p.g1 = rnd_val(); p.g2 = rnd_val(); p.zz = rnd_val();
    p.row = IDX_W'($urandom); p.col = IDX_W'($urandom);
    p.sx = p.fx + offset(655360);
    p.sy = p.fy + offset(655360);
    p.sz = p.fz + offset(655360);
    if (mode == 6) begin
      p.sx = $urandom; p.sy = $urandom; p.sz = $urandom;
      p.fx = $urandom; p.g1 = $urandom; p.zz = $urandom;
    end else if (mode == 7) begin
      p.sx = p.fx; p.sy = p.fy; p.sz = p.fz;
    end else if (mode == 8) begin
      p.sx = p.fx + offset(1); p.sy = p.fy + offset(1); p.sz = p.fz;
    end else if (mode == 9) begin
      p.sx = p.fx + 32'(327680) + offset(2);
      p.sy = p.fy; p.sz = p.fz;
    end
    return p;
  endfunction

  task automatic send_pair(input pair_t p);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    first_x <= p.fx; first_y <= p.fy; first_z <= p.fz;
    second_x <= p.sx; second_y <= p.sy; second_z <= p.sz;
    first_gyro <= p.g1; second_gyro <= p.g2; coupling_zz <= p.zz;
    pair_row <= p.row; pair_col <= p.col;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic directed_pair(input logic [31:0] fx, sx, g1, g2, zz,
                               input logic [IDX_W-1:0] row, col);
    pair_t p;
    p.fx = fx; p.sx = sx; p.fy = fx; p.sy = fx; p.fz = 0; p.sz = 0;
    p.g1 = g1; p.g2 = g2; p.zz = zz; p.row = row; p.col = col;
    send_pair(p);
  endtask

  initial begin
    pair_t p;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // zero distance, also with zero numerator
    directed_pair(32'h0001_0000, 32'h0001_0000, 0, 0, 0, 1, 1);
    directed_pair(32'h8000_0000, 32'h8000_0000, 32'h0100_0000, 32'h0100_0000,
                  32'h0001_0000, 11'h7FF, 0);
    // one lsb apart
    directed_pair(0, 1, 32'h0100_0000, 32'h0100_0000, 32'h0001_0000, 1024, 1024);
    directed_pair(0, 1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 2, 3);
    // largest spread on all axes
    p.fx = 32'h8000_0000; p.fy = 32'h8000_0000; p.fz = 32'h8000_0000;
    p.sx = 32'h7FFF_FFFF; p.sy = 32'h7FFF_FFFF; p.sz = 32'h7FFF_FFFF;
    p.g1 = 32'h7FFF_FFFF; p.g2 = 32'h7FFF_FFFF; p.zz = 32'h7FFF_FFFF;
    p.row = 11'h7FF; p.col = 11'h7FF;
    send_pair(p);
    p.g1 = 32'h0000_0001; p.g2 = 32'h0000_0001; p.zz = 32'hFFFF_FFFF;
    send_pair(p);
    // on and just inside the outer bound
    directed_pair(0, 32'd327680, 32'h0100_0000, 32'hFF00_0000, 32'h0001_0000, 5, 6);
    directed_pair(0, 32'd327679, 32'h0100_0000, 32'hFF00_0000, 32'hFFFF_0000, 6, 5);
    directed_pair(32'd327680, 0, 32'h0100_0000, 32'h0100_0000, 32'h0001_0000, 7, 8);
    // ordinary pair with negative coordinates and factors, then a pair with a zero gyro ratio
    directed_pair(32'hFFFE_0000, 32'h0000_8000, 32'hF000_0000, 32'h0800_0000,
                  32'hFFF0_0000, 10, 20);
    directed_pair(32'h7FFF_FFFF, 32'h7FFF_0000, 32'h0000_0000, 32'h7FFF_FFFF,
                  32'h0001_0000, 0, 11'h7FF);

    for (int ph = 0; ph < 6; ph++) begin
      drain();
      case (ph)
        0: begin
          send_idle_pct = 0; stall_pct = 0;
          write_reg(REG_INNER, 32'd65536);
        end
        1: begin
          send_idle_pct = 52; stall_pct = 0;
          write_reg(REG_OUTER, 32'h7FFF_FFFF);
          write_reg(REG_INNER, 32'd0);
          write_reg(REG_HBAR, 32'hFFFF_FFFF);
        end
        2: begin
          send_idle_pct = 0; stall_pct = 52;
          write_reg(REG_OUTER, 32'd65536);
          write_reg(REG_INNER, 32'd327680);
          write_reg(REG_HBAR, 32'd0);
        end
        3: begin
          send_idle_pct = 36; stall_pct = 36;
          write_reg(REG_OUTER, 32'd655360);
          write_reg(REG_INNER, 32'd32768);
          write_reg(REG_HBAR, 32'h0000_0001);
          write_reg(REG_UNUSED, 32'hFFFF_FFFF);
        end
        4: begin
          send_idle_pct = 36; stall_pct = 36;
          write_reg(REG_OUTER, 32'h0000_0000);
          write_reg(REG_INNER, 32'h7FFF_FFFF);
          write_reg(REG_HBAR, 32'h0001_0000);
        end
        default: begin
          send_idle_pct = 0; stall_pct = 0;
          write_reg(REG_OUTER, 32'hFFFF_FFFF);
          write_reg(REG_INNER, 32'h0000_0001);
          write_reg(REG_HBAR, 32'h0000_8000);
        end
      endcase
      if (ph == 3) begin
        directed_pair(0, 32'd32768, 32'h0100_0000, 32'h0100_0000, 32'h0001_0000, 9, 9);
        directed_pair(0, 32'd655360, 32'h0100_0000, 32'h0100_0000, 32'h0001_0000, 9, 9);
      end
      for (int i = 0; i < ((ph < 4) ? PHASE_ITEMS : 30); i++) begin
        if (ph == 2 && i == PHASE_ITEMS / 2) begin
          in_valid <= 1'b0;
          @(negedge clk);
          while (pending != 0) @(negedge clk);
        end
        send_pair(rand_pair());
      end
    end

    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
